// ----- src/vbm_pkg.sv -----
// ----------------------------------------------------------------------------
// vbm_pkg
// Shared constants, types and state codes of the voice bus mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package vbm_pkg;

	localparam int MAX_VOICES_DEF       = 64;
	localparam int MAX_BUSES_DEF        = 16;
	localparam int MAX_OUT_CHANNELS_DEF = 8;

	localparam int VOICE_W = 6;
	localparam int BUS_W   = 4;
	localparam int BUS_AW  = 6;
	localparam int CHAN_W  = 3;
	localparam int GAIN_W  = 16;
	localparam int SMP_W   = 16;
	localparam int ACC_W   = 40;
	localparam int SUM_W   = 64;
	localparam int OC_W    = 4;

	localparam logic [OC_W-1:0] OC_RESET = 4'd2;

	typedef enum logic [1:0] {
		FN_SET_BUS   = 2'd0,
		FN_SET_CGAIN = 2'd1,
		FN_SET_BGAIN = 2'd2,
		FN_MIX       = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_LOOK,
		S_ACC,
		S_WALK,
		S_DRAIN,
		S_OUT
	} state_t;

	// Control bundle sent from the sequencer to each channel lane.
	typedef struct packed {
		logic                     gain_we;
		logic [VOICE_W-1:0]       voice;
		logic [GAIN_W-1:0]        gain;
		logic [BUS_AW-1:0]        acc_addr;
		logic                     acc_we;
		logic signed [SMP_W-1:0]  mono;
		logic [GAIN_W-1:0]        bus_gain;
		logic                     sum_clr;
		logic                     sum_en;
		logic                     acc_clr;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ----- src/vbm_in_if.sv -----
// ----------------------------------------------------------------------------
// vbm_in_if
// Input item channel: routing writes and source frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [5:0]  voice;
	logic [3:0]  bus;
	logic [2:0]  channel;
	logic [15:0] gain;
	logic signed [15:0] sample_first;
	logic signed [15:0] sample_second;
	logic        src_stereo;
	logic        frame_end;

	modport source (output valid, func, voice, bus, channel, gain, sample_first,
		sample_second, src_stereo, frame_end, input ready);
	modport sink (input valid, func, voice, bus, channel, gain, sample_first,
		sample_second, src_stereo, frame_end, output ready);
endinterface

`default_nettype wire

// ----- src/vbm_out_if.sv -----
// ----------------------------------------------------------------------------
// vbm_out_if
// Result channel: one master sample per used output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbm_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_channel;
	logic signed [15:0] out_sample;
	logic        last;

	modport source (output valid, out_channel, out_sample, last, input ready);
	modport sink (input valid, out_channel, out_sample, last, output ready);
endinterface

`default_nettype wire

// ----- src/voice_bus_mixer.sv -----
// ----------------------------------------------------------------------------
// voice_bus_mixer
// Mixes voices into submix buses and the buses into one master frame.
// ----------------------------------------------------------------------------
// Items arrive on the item channel. Routing items (set bus, set channel gain,
// set bus gain) complete at their transfer and item.ready stays high. A mix
// item passes through the transfer, the lookup of the voice bus and gains,
// the product in every channel lane at once, and the saturating accumulate.
// A mix item with frame_end then walks buses 1 to MAX_BUSES-1, one bus a
// cycle through each lane's multiplier, drains the v_s1 and v_s2 pipeline
// registers into the lane sums and then starts the load of the first result.
// Results leave through an output register, one channel a cycle while
// result.ready is high; a stalled receiver holds the result and blocks new
// items until the frame's last result is loaded into that register.
// After reset the voice channel gains are cleared by a pass over all
// MAX_VOICES voices with item.ready low; routes and accumulators are cleared
// at once. out_channels resets to 2 and cfg_we writes it at any clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_bus_mixer #(
	parameter int MAX_VOICES       = vbm_pkg::MAX_VOICES_DEF,
	parameter int MAX_BUSES        = vbm_pkg::MAX_BUSES_DEF,
	parameter int MAX_OUT_CHANNELS = vbm_pkg::MAX_OUT_CHANNELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [vbm_pkg::OC_W-1:0]  cfg_wdata,
	vbm_in_if.sink                         item,
	vbm_out_if.source                      result
);
	import vbm_pkg::*;

	localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int BIW = $clog2(MAX_BUSES);

	state_t state_q, state_d;

	logic [OC_W-1:0]         oc_q;
	logic [OC_W-1:0]         oc_use;
	logic                    accept;
	logic [VOICE_W-1:0]      voice_q;
	logic signed [SMP_W-1:0] mono_q;
	logic signed [SMP_W:0]   pair;
	logic                    fend_q;
	logic                    voice_ok_q;

	logic [BUS_W-1:0]        bsel_mem [MAX_VOICES];
	logic [MAX_VOICES-1:0]   bsel_vld_q;
	logic [BUS_W-1:0]        vb_rd_q;
	logic [BUS_W-1:0]        vb_q;
	logic                    mix_ok_q;
	logic                    bsel_we;

	logic [GAIN_W-1:0]       bg_mem [MAX_BUSES];
	logic [MAX_BUSES-1:0]    bg_vld_q;
	logic [GAIN_W-1:0]       bg_rd_q;
	logic                    bg_we;

	logic [BIW-1:0]          b_q;
	logic                    v_s1, v_s2;
	logic                    start;
	logic                    busy;
	logic [VIW-1:0]          init_q;

	logic [VIW-1:0]          wva, rva;
	logic [BIW-1:0]          wba;

	lane_ctl_t               ctl [MAX_OUT_CHANNELS];
	logic signed [SUM_W-1:0] sums [MAX_OUT_CHANNELS];

	assign accept = item.valid && item.ready;
	assign wva    = VIW'(item.voice);
	assign wba    = BIW'(item.bus);
	assign rva    = VIW'(voice_q);

	always_comb begin
		if (oc_q == '0) begin
			oc_use = OC_W'(1);
		end else if (int'(oc_q) > MAX_OUT_CHANNELS) begin
			oc_use = OC_W'(MAX_OUT_CHANNELS);
		end else begin
			oc_use = oc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q <= OC_RESET;
		end else if (cfg_we) begin
			oc_q <= cfg_wdata;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:  if (init_q == VIW'(MAX_VOICES - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept && item.func == FN_MIX) state_d = S_RD;
			S_RD:    state_d = S_LOOK;
			S_LOOK:  state_d = S_ACC;
			S_ACC:   state_d = fend_q ? S_WALK : S_IDLE;
			S_WALK:  if (b_q == BIW'(MAX_BUSES - 1)) state_d = S_DRAIN;
			S_DRAIN: if (!v_s1 && !v_s2) state_d = S_OUT;
			S_OUT:   if (!busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item.ready = (state_q == S_IDLE);
		bsel_we    = accept && item.func == FN_SET_BUS
			&& int'(item.voice) < MAX_VOICES && int'(item.bus) < MAX_BUSES;
		bg_we      = accept && item.func == FN_SET_BGAIN && int'(item.bus) < MAX_BUSES;
		start      = (state_q == S_DRAIN) && !v_s1 && !v_s2;
		for (int c = 0; c < MAX_OUT_CHANNELS; c++) begin
			// The clearing pass after reset writes zero gains at every voice.
			ctl[c].gain_we  = (state_q == S_INIT) || (accept && item.func == FN_SET_CGAIN
				&& int'(item.voice) < MAX_VOICES && int'(item.channel) == c);
			ctl[c].voice    = (state_q == S_INIT) ? VOICE_W'(init_q)
				: ((state_q == S_IDLE) ? item.voice : voice_q);
			ctl[c].gain     = (state_q == S_INIT) ? '0 : item.gain;
			unique case (state_q)
				S_LOOK:  ctl[c].acc_addr = BUS_AW'(vb_rd_q);
				S_ACC:   ctl[c].acc_addr = BUS_AW'(vb_q);
				default: ctl[c].acc_addr = BUS_AW'(b_q);
			endcase
			ctl[c].acc_we   = (state_q == S_ACC) && mix_ok_q && c < int'(oc_use);
			ctl[c].mono     = mono_q;
			ctl[c].bus_gain = bg_rd_q;
			ctl[c].sum_clr  = (state_q == S_ACC);
			ctl[c].sum_en   = v_s2;
			ctl[c].acc_clr  = start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_q     <= '0;
			bsel_vld_q <= '0;
			bg_vld_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			b_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) init_q <= init_q + VIW'(1);
			if (bsel_we) bsel_vld_q[wva] <= 1'b1;
			if (bg_we) bg_vld_q[wba] <= 1'b1;
			v_s1 <= (state_q == S_WALK);
			v_s2 <= v_s1;
			if (state_q == S_ACC) begin
				b_q <= BIW'(1);
			end else if (state_q == S_WALK) begin
				b_q <= b_q + BIW'(1);
			end
		end
	end

	assign pair = SMP_W'(0) + ((SMP_W+1)'(item.sample_first)
		+ (SMP_W+1)'(item.sample_second));

	always_ff @(posedge clk) begin
		if (bsel_we) bsel_mem[wva] <= item.bus;
		if (bg_we) bg_mem[wba] <= item.gain;
		vb_rd_q <= bsel_vld_q[rva] ? bsel_mem[rva] : '0;
		bg_rd_q <= bg_vld_q[b_q] ? bg_mem[b_q] : '0;
		if (accept) begin
			voice_q    <= item.voice;
			voice_ok_q <= int'(item.voice) < MAX_VOICES;
			fend_q     <= item.frame_end;
			// The arithmetic shift floors the stereo average.
			mono_q     <= item.src_stereo ? SMP_W'(pair >>> 1) : item.sample_first;
		end
		if (state_q == S_LOOK) begin
			vb_q     <= vb_rd_q;
			mix_ok_q <= voice_ok_q && vb_rd_q != '0 && int'(vb_rd_q) < MAX_BUSES;
		end
	end

	for (genvar g = 0; g < MAX_OUT_CHANNELS; g++) begin : g_lane
		vbm_lane #(
			.NV(MAX_VOICES),
			.NB(MAX_BUSES)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.sum(sums[g])
		);
	end

	vbm_merge #(
		.NCH(MAX_OUT_CHANNELS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.oc(oc_use),
		.sums(sums),
		.busy(busy),
		.result(result)
	);

endmodule

`default_nettype wire

// ----- src/vbm_lane.sv -----
// ----------------------------------------------------------------------------
// vbm_lane
// One output channel lane: voice gains, bus accumulators and the bus sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vbm_lane #(
	parameter int NV = vbm_pkg::MAX_VOICES_DEF,
	parameter int NB = vbm_pkg::MAX_BUSES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire vbm_pkg::lane_ctl_t              ctl,
	output logic signed [vbm_pkg::SUM_W-1:0]     sum
);
	import vbm_pkg::*;

	localparam int VIW = (NV > 1) ? $clog2(NV) : 1;
	localparam int BIW = $clog2(NB);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic [GAIN_W-1:0]        gain_mem [NV];
	logic [GAIN_W-1:0]        gain_rd_q;
	logic signed [ACC_W-1:0]  acc_mem [NB];
	logic [NB-1:0]            acc_vld_q;
	logic signed [ACC_W-1:0]  acc_rd_q;
	logic signed [32:0]       mix_s2;
	logic signed [56:0]       prod_s2;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_new;

	logic [VIW-1:0] va;
	logic [BIW-1:0] ba;

	assign va = VIW'(ctl.voice);
	assign ba = BIW'(ctl.acc_addr);

	always_ff @(posedge clk) begin
		if (ctl.gain_we) begin
			gain_mem[va] <= ctl.gain;
		end
		gain_rd_q <= gain_mem[va];
		if (ctl.acc_we) begin
			acc_mem[ba] <= acc_new;
		end
		acc_rd_q <= acc_vld_q[ba] ? acc_mem[ba] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q  <= '0;
		end else begin
			if (ctl.acc_clr) begin
				acc_vld_q <= '0;
			end else if (ctl.acc_we) begin
				acc_vld_q[ba] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		mix_s2  <= ctl.mono * $signed({1'b0, gain_rd_q});
		prod_s2 <= acc_rd_q * $signed({1'b0, ctl.bus_gain});
		if (ctl.sum_clr) begin
			sum_q <= '0;
		end else if (ctl.sum_en) begin
			sum_q <= sum_q + SUM_W'(prod_s2);
		end
	end

	always_comb begin
		acc_sum = (ACC_W+1)'(acc_rd_q) + (ACC_W+1)'(mix_s2);
		if (acc_sum > (ACC_W+1)'(ACC_MAX)) begin
			acc_new = ACC_MAX;
		end else if (acc_sum < (ACC_W+1)'(ACC_MIN)) begin
			acc_new = ACC_MIN;
		end else begin
			acc_new = acc_sum[ACC_W-1:0];
		end
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

// ----- src/vbm_merge.sv -----
// ----------------------------------------------------------------------------
// vbm_merge
// Rounds and saturates the lane sums and sends them out one channel a time.
// ----------------------------------------------------------------------------
`default_nettype none

module vbm_merge #(
	parameter int NCH = vbm_pkg::MAX_OUT_CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [vbm_pkg::OC_W-1:0]      oc,
	input  wire logic signed [vbm_pkg::SUM_W-1:0] sums [NCH],
	output logic                               busy,
	vbm_out_if.source                          result
);
	import vbm_pkg::*;

	localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

	logic                    busy_q;
	logic [CW-1:0]           idx_q;
	logic                    out_v_q;
	logic [CHAN_W-1:0]       out_ch_q;
	logic signed [SMP_W-1:0] out_smp_q;
	logic                    out_last_q;
	logic signed [SUM_W-1:0] rounded;
	logic signed [SUM_W-29:0] shifted;
	logic signed [SMP_W-1:0] sat;
	logic                    load;
	logic                    is_last;

	always_comb begin
		rounded = sums[idx_q] + (SUM_W'(1) <<< 27);
		shifted = rounded[SUM_W-1:28];
		if (shifted > (SUM_W-28)'(32767)) begin
			sat = 16'sh7FFF;
		end else if (shifted < -(SUM_W-28)'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = shifted[SMP_W-1:0];
		end
	end

	assign load    = busy_q && (!out_v_q || result.ready);
	assign is_last = (OC_W'(idx_q) == oc - OC_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + CW'(1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ch_q   <= CHAN_W'(idx_q);
			out_smp_q  <= sat;
			out_last_q <= is_last;
		end
	end

	assign busy               = busy_q;
	assign result.valid       = out_v_q;
	assign result.out_channel = out_ch_q;
	assign result.out_sample  = out_smp_q;
	assign result.last        = out_last_q;

endmodule

`default_nettype wire

// ----- src/vbm_checker.sv -----
// ----------------------------------------------------------------------------
// vbm_checker
// Port-level checks of the voice bus mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vbm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  in_func,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  out_channel,
	input wire logic [15:0] out_sample,
	input wire logic        out_last
);
	import vbm_pkg::*;

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample)
			&& $stable(out_channel) && $stable(out_last))
		else $error("stalled result changed");

	// A mix transfer occupies the block for its lookup and accumulate.
	a_mix_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == FN_MIX |=> !in_ready)
		else $error("item taken during mix");

	// Routing writes finish at their transfer.
	a_route_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func != FN_MIX |=> in_ready)
		else $error("routing write stalled the block");

	// Channel seven, the top channel, always closes its frame when it is sent.
	a_last_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_channel == 3'd7 |-> out_last)
		else $error("channel seven not last");

endmodule

bind voice_bus_mixer vbm_checker u_vbm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.in_func(item.func),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_channel(result.out_channel),
	.out_sample(result.out_sample),
	.out_last(result.last)
);

`default_nettype wire

// ----- sim/voice_bus_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// voice_bus_mixer_tb
// Self-checking bench for the voice bus mixer. A directed table covers reset
// values, routing extremes and saturation; random routing and frame traffic
// follows. Every master sample is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_bus_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vbm_pkg::*;

	localparam int NV = 64;
	localparam int NB = 16;
	localparam int NC = 8;
	localparam int WATCHDOG = 20000;

	typedef struct {
		func_t            fn;
		logic [5:0]       voice;
		logic [3:0]       bus;
		logic [2:0]       channel;
		logic [15:0]      gain;
		logic signed [15:0] s0;
		logic signed [15:0] s1;
		logic             stereo;
		logic             fend;
		logic             chk;
		logic signed [15:0] want;
	} mix_item_t;

	typedef struct {
		logic [2:0]       chan;
		logic signed [15:0] smp;
		logic             last;
	} master_smp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;

	vbm_in_if  item ();
	vbm_out_if result ();

	voice_bus_mixer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item(item.sink), .result(result.source)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [15:0] gain_tbl [NV*NC];
	logic [3:0]  route_tbl [NV];
	logic [15:0] bgain_tbl [NB];
	longint      bus_acc [NB*NC];
	logic [3:0]  oc_reg;

	master_smp_t expected_q [$];
	logic signed [15:0] forced_q [$];
	logic        forced_on [$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit hold_off = 0;
	bit held = 0;

	function automatic longint floor_sh(longint x, int n);
		return x >>> n;
	endfunction

	task automatic predict_item(input mix_item_t it);
		int oc;
		longint mono, s, sum, r;
		int vb;
		master_smp_t m;
		oc = (oc_reg == 4'd0) ? 1 : ((int'(oc_reg) > NC) ? NC : int'(oc_reg));
		case (it.fn)
			FN_SET_BUS:   route_tbl[it.voice] = it.bus;
			FN_SET_CGAIN: gain_tbl[it.voice*NC + it.channel] = it.gain;
			FN_SET_BGAIN: bgain_tbl[it.bus] = it.gain;
			default: begin
				vb = int'(route_tbl[it.voice]);
				if (vb != 0) begin
					mono = it.stereo ? floor_sh(longint'(it.s0) + longint'(it.s1), 1)
						: longint'(it.s0);
					for (int c = 0; c < oc; c++) begin
						s = bus_acc[vb*NC + c] + mono * longint'(gain_tbl[it.voice*NC + c]);
						if (s > 64'sd549755813887) s = 64'sd549755813887;
						if (s < -64'sd549755813888) s = -64'sd549755813888;
						bus_acc[vb*NC + c] = s;
					end
				end
				if (it.fend) begin
					for (int c = 0; c < oc; c++) begin
						sum = 0;
						for (int b = 1; b < NB; b++)
							sum += bus_acc[b*NC + c] * longint'(bgain_tbl[b]);
						r = floor_sh(sum + (64'sd1 <<< 27), 28);
						if (r > 32767) r = 32767;
						if (r < -32768) r = -32768;
						m.chan = c[2:0];
						m.smp = r[15:0];
						m.last = (c == oc - 1);
						expected_q.insert(expected_q.size(), m);
						forced_on.insert(forced_on.size(), it.chk && c == 0);
						forced_q.insert(forced_q.size(), it.want);
					end
					for (int i = 0; i < NB*NC; i++) bus_acc[i] = 0;
				end
			end
		endcase
	endtask

	// Sender side.
	task automatic send_item(input mix_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.func <= it.fn;
		item.voice <= it.voice;
		item.bus <= it.bus;
		item.channel <= it.channel;
		item.gain <= it.gain;
		item.sample_first <= it.s0;
		item.sample_second <= it.s1;
		item.src_stereo <= it.stereo;
		item.frame_end <= it.fend;
		do @(posedge clk); while (!item.ready);
		predict_item(it);
	endtask

	task automatic end_item();
		item.valid <= 1'b0;
	endtask

	task automatic set_channels(input logic [3:0] v);
		item.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		oc_reg = v;
	endtask

	function automatic mix_item_t mk(func_t f, int v, int b, int ch, int g,
			int a, int bb, bit st, bit fe);
		mix_item_t it;
		it.fn = f; it.voice = 6'(v); it.bus = 4'(b); it.channel = 3'(ch);
		it.gain = 16'(g);
		it.s0 = 16'(a); it.s1 = 16'(bb); it.stereo = st; it.fend = fe;
		it.chk = 1'b0; it.want = '0;
		return it;
	endfunction

	function automatic mix_item_t rnd_item(bit frame_heavy);
		mix_item_t it;
		int k;
		k = $urandom_range(0, 9);
		it = mk(FN_MIX, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
			1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
		if (k < 2) it.fn = FN_SET_CGAIN;
		else if (k < 3) it.fn = FN_SET_BUS;
		else if (k < 4) it.fn = FN_SET_BGAIN;
		if ($urandom_range(0, 7) == 0) it.voice = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 3) == 0) it.gain = 16'($urandom_range(0, 20000));
		if (frame_heavy && it.fn == FN_MIX) it.fend = 1'($urandom_range(0, 1));
		return it;
	endfunction

	mix_item_t dir_tbl [$];

	function automatic void add_row(input mix_item_t r);
		dir_tbl.insert(dir_tbl.size(), r);
	endfunction

	initial begin
		mix_item_t it;
		item.valid = 1'b0;
		item.func = FN_SET_BUS; item.voice = '0; item.bus = '0; item.channel = '0;
		item.gain = '0; item.sample_first = '0; item.sample_second = '0;
		item.src_stereo = 1'b0; item.frame_end = 1'b0;
		for (int i = 0; i < NV*NC; i++) gain_tbl[i] = '0;
		for (int i = 0; i < NV; i++) route_tbl[i] = '0;
		for (int i = 0; i < NB; i++) bgain_tbl[i] = '0;
		for (int i = 0; i < NB*NC; i++) bus_acc[i] = 0;
		oc_reg = OC_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset everything is zero, so a frame gives silence.
		it = mk(FN_MIX, 0, 0, 0, 0, 32767, 0, 0, 1); it.chk = 1'b1; it.want = '0;
		add_row(it);
		add_row(mk(FN_SET_BUS, 63, 15, 0, 0, 0, 0, 0, 1));
		add_row(mk(FN_SET_CGAIN, 63, 0, 0, 16'hFFFF, 0, 0, 0, 1));
		add_row(mk(FN_SET_CGAIN, 63, 0, 1, 16'h4000, 0, 0, 0, 0));
		add_row(mk(FN_SET_CGAIN, 63, 0, 7, 16'h4000, 0, 0, 0, 0));
		add_row(mk(FN_SET_BGAIN, 0, 15, 0, 16'hFFFF, 0, 0, 0, 0));
		add_row(mk(FN_SET_BGAIN, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
		// Full scale with almost 4x gains on both stages saturates high.
		it = mk(FN_MIX, 63, 0, 0, 0, 32767, 0, 0, 1); it.chk = 1'b1; it.want = 16'sd32767;
		add_row(it);
		it = mk(FN_MIX, 63, 0, 0, 0, -32768, -32768, 1, 1); it.chk = 1'b1;
		it.want = -16'sd32768;
		add_row(it);
		add_row(mk(FN_MIX, 63, 0, 0, 0, 32767, -32768, 1, 0));
		add_row(mk(FN_MIX, 63, 0, 0, 0, -1, 0, 1, 1));
		add_row(mk(FN_SET_BUS, 5, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(FN_SET_CGAIN, 5, 0, 0, 16'h4000, 0, 0, 0, 0));
		add_row(mk(FN_SET_BGAIN, 0, 0, 0, 16'h4000, 0, 0, 0, 0));
		// Voice on bus 0 contributes nothing.
		it = mk(FN_MIX, 5, 0, 0, 0, 12345, 0, 0, 1); it.chk = 1'b1; it.want = '0;
		add_row(it);
		add_row(mk(FN_SET_BUS, 10, 3, 0, 0, 0, 0, 0, 0));
		add_row(mk(FN_SET_CGAIN, 10, 0, 0, 16'h4000, 0, 0, 0, 0));
		add_row(mk(FN_SET_BGAIN, 0, 3, 0, 16'h4000, 0, 0, 0, 0));
		add_row(mk(FN_MIX, 10, 0, 0, 0, 16'h5555, 16'hAAAA, 1, 0));
		add_row(mk(FN_MIX, 63, 0, 0, 0, 16'h8000, 16'h7FFF, 0, 1));
		foreach (dir_tbl[i]) send_item(dir_tbl[i]);
		end_item();

		set_channels(4'd8);
		for (int i = 0; i < 8; i++) send_item(mk(FN_SET_CGAIN, 63, 0, i, 16'h2000 + i, 0, 0, 0, 0));
		send_item(mk(FN_MIX, 63, 0, 0, 0, 20000, 0, 0, 1));
		set_channels(4'd0);
		send_item(mk(FN_MIX, 63, 0, 0, 0, -20000, 0, 0, 1));
		set_channels(4'd15);
		send_item(mk(FN_MIX, 63, 0, 0, 0, 1000, 0, 0, 1));
		set_channels(4'd1);
		// Route the low voices somewhere live so random frames have content.
		for (int v = 0; v < 16; v++) send_item(mk(FN_SET_BUS, v, 1 + v % 15, 0, 0, 0, 0, 0, 0));

		for (int phase = 0; phase < 4; phase++) begin
			set_channels(phase == 0 ? 4'd3 : (phase == 1 ? 4'd8 : (phase == 2 ? 4'd5 : 4'd2)));
			if (phase == 3) calm = 1;
			for (int n = 0; n < 50; n++) send_item(rnd_item(phase == 1));
			if (phase == 1) begin
				hold_off = 1;
				for (int n = 0; n < 12; n++) begin
					it = rnd_item(0); it.fn = FN_MIX; it.fend = 1'b1;
					send_item(it);
				end
				end_item();
				hold_off = 0;
			end
		end
		end_item();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver side, with random stalls and one long hold-off.
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1;
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		master_smp_t w;
		logic f;
		logic signed [15:0] fv;
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("Mismatches found");
				$finish;
			end
		end
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer ch=%0d smp=%0d last=%0d",
						result.out_channel, result.out_sample, result.last);
			end else begin
				w = expected_q.pop_front();
				f = forced_on.pop_front();
				fv = forced_q.pop_front();
				if (f) w.smp = fv;
				if (w.chan !== result.out_channel || w.smp !== result.out_sample ||
						w.last !== result.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ch=%0d smp=%0d last=%0d got ch=%0d smp=%0d last=%0d",
							w.chan, w.smp, w.last, result.out_channel, result.out_sample,
							result.last);
				end
			end
		end
	end
endmodule

`default_nettype wire
